// File: rtl/core/json_string_escaper_macros.svh
// Assertion macros for the JSON string escaper.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef JSON_STRING_ESCAPER_MACROS_SVH
`define JSON_STRING_ESCAPER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on the rising clock, off while reset is active.
`define JSE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("jse check failed: implication");

// Next-cycle implication, sampled on the rising clock, off while reset is active.
`define JSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("jse check failed: next-cycle implication");

`else

`define JSE_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define JSE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/jse_pkg.sv
`timescale 1ns / 1ps
// Package for the JSON string escaper: request codes, character constants,
// run-length type and the hex digit helper. No dependencies.
package jse_pkg;

	// Request codes on req_type
	typedef enum logic [1:0] {
		REQ_DATA  = 2'd0,
		REQ_START = 2'd1,
		REQ_END   = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	// Character constants
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;

	// Bytes below this are control characters
	localparam logic [7:0] CTRL_LIMIT = 8'h20;

	// Output run length, 1 to 6 bytes
	typedef logic [2:0] run_len_t;

	localparam run_len_t LEN_PLAIN = 3'd1;
	localparam run_len_t LEN_SHORT = 3'd2;
	localparam run_len_t LEN_UNI   = 3'd6;

	// Lowercase hex digit for one nibble
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) begin
			r = CH_ZERO + {4'd0, nib};
		end else begin
			r = CH_LOW_A + {4'd0, nib} - 8'd10;
		end
		return r;
	endfunction

endpackage

// File: rtl/core/json_string_escaper.sv
`timescale 1ns / 1ps
// Top level of the JSON string escaper: input register, decode stage,
// byte expander and output register. Depends on jse_pkg and the macro header.
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------
//  in      | in_valid / in_ready | req_type[1:0], data_byte[7:0]
//  out     | out_valid/out_ready | out_byte[7:0], last_of_run
//
// An input transaction is taken every cycle while the output keeps up; an item
// that expands to N bytes (1, 2 or 6) holds the expander until all N bytes have
// gone out, which sets the sustained rate. Reset clears all valid bits; payload
// registers are not reset. Stalls on the output back up stage by stage without
// losing or repeating a transaction.
`include "json_string_escaper_macros.svh"

module json_string_escaper
	import jse_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] req_type,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       last_of_run
);

	// Stage 1: registered input
	logic       v_s1;
	req_t       req_s1;
	logic [7:0] byte_s1;

	// Stage 2: decoded escape
	logic       v_s2;
	run_len_t   len_s2;
	logic [7:0] ch_s2;
	logic [7:0] hi_s2;
	logic [7:0] lo_s2;

	// Stage 3: expander
	logic       v_s3;
	run_len_t   len_s3;
	logic [7:0] ch_s3;
	logic [7:0] hi_s3;
	logic [7:0] lo_s3;
	run_len_t   idx_q;

	// Stage 4: output register
	logic       v_s4;
	logic [7:0] byte_s4;
	logic       last_s4;

	// Handshake between stages
	logic       out_free;
	logic       emit;
	logic       run_done;
	logic       load_s3;
	logic       take_s2;
	logic       take_s1;
	logic [7:0] cur_byte;

	// Decode results
	run_len_t   dec_len;
	logic [7:0] dec_ch;

	assign out_free = !v_s4 || out_ready;
	assign emit     = v_s3 && out_free;
	assign run_done = (idx_q == (len_s3 - LEN_PLAIN));
	assign load_s3  = !v_s3 || (emit && run_done);
	assign take_s2  = !v_s2 || load_s3;
	assign take_s1  = !v_s1 || take_s2;
	assign in_ready = take_s1;

	// Stage 1 register; the unused request code is dropped here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take_s1) begin
			v_s1 <= in_valid && (req_t'(req_type) != REQ_NONE);
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			req_s1  <= req_t'(req_type);
			byte_s1 <= data_byte;
		end
	end

	// Escape decode
	always_comb begin
		dec_len = LEN_SHORT;
		dec_ch  = byte_s1;
		unique case (req_s1)
			REQ_START, REQ_END: begin
				dec_len = LEN_PLAIN;
				dec_ch  = CH_QUOTE;
			end
			REQ_DATA: begin
				case (byte_s1)
					CH_QUOTE, CH_BSLASH: dec_ch = byte_s1;
					CH_BS:  dec_ch = CH_B;
					CH_FF:  dec_ch = CH_F;
					CH_LF:  dec_ch = CH_N;
					CH_CR:  dec_ch = CH_R;
					CH_TAB: dec_ch = CH_T;
					default: begin
						if (byte_s1 < CTRL_LIMIT) begin
							dec_len = LEN_UNI;
							dec_ch  = CH_U;
						end else begin
							dec_len = LEN_PLAIN;
							dec_ch  = byte_s1;
						end
					end
				endcase
			end
			default: begin
				dec_len = LEN_PLAIN;
				dec_ch  = byte_s1;
			end
		endcase
	end

	// Stage 2 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (take_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s2) begin
			len_s2 <= dec_len;
			ch_s2  <= dec_ch;
			hi_s2  <= hex_char(byte_s1[7:4]);
			lo_s2  <= hex_char(byte_s1[3:0]);
		end
	end

	// Stage 3 register and byte counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3  <= 1'b0;
			idx_q <= '0;
		end else if (load_s3) begin
			v_s3  <= v_s2;
			idx_q <= '0;
		end else if (emit) begin
			idx_q <= idx_q + LEN_PLAIN;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s3) begin
			len_s3 <= len_s2;
			ch_s3  <= ch_s2;
			hi_s3  <= hi_s2;
			lo_s3  <= lo_s2;
		end
	end

	// Byte for the current run position
	always_comb begin
		if (len_s3 == LEN_PLAIN) begin
			cur_byte = ch_s3;
		end else begin
			case (idx_q)
				3'd0:       cur_byte = CH_BSLASH;
				3'd1:       cur_byte = ch_s3;
				3'd2, 3'd3: cur_byte = CH_ZERO;
				3'd4:       cur_byte = hi_s3;
				default:    cur_byte = lo_s3;
			endcase
		end
	end

	// Stage 4: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (out_free) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_s4 <= cur_byte;
			last_s4 <= run_done;
		end
	end

	assign out_valid   = v_s4;
	assign out_byte    = byte_s4;
	assign last_of_run = last_s4;

	// Checks
	`JSE_ASSERT_IMPLY(a_idx_in_run, clk, arst_n, v_s3, idx_q < len_s3)
	`JSE_ASSERT_IMPLY(a_run_open, clk, arst_n, v_s4 && !last_s4, v_s3 && (idx_q != 3'd0))
	`JSE_ASSERT_NEXT(a_run_advance, clk, arst_n, emit && !run_done, v_s3 && (idx_q != 3'd0))

endmodule

// File: tb/json_escape_checker.sv
`timescale 1ns / 1ps
// Checker for the JSON string escaper: watches both channels, predicts the escaped
// bytes of every input transaction and compares them in order. Depends on jse_pkg.
module json_escape_checker
	import jse_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [1:0] req_type,
	input  logic [7:0] data_byte,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] out_byte,
	input  logic       last_of_run,
	output int         error_count,
	output int         bytes_pending,
	output int         bytes_checked
);

	localparam int REPORT_LIMIT = 10;

	// One expected output byte and its end-of-run flag
	typedef struct packed {
		logic [7:0] char_val;
		logic       last;
	} esc_byte_t;

	esc_byte_t escaped_q[$];
	esc_byte_t want;
	int        mismatches;
	int        checked;
	string     hex_digits = "0123456789abcdef";

	function automatic void push_byte(input logic [7:0] c, input logic last);
		esc_byte_t e;
		e.char_val = c;
		e.last     = last;
		escaped_q.push_back(e);
	endfunction

	// Expected byte run of one input transaction
	function automatic void expand_item(input req_t kind, input logic [7:0] b);
		logic       is_short;
		logic [7:0] short_code;
		is_short   = 1'b1;
		short_code = b;
		case (kind)
			REQ_START, REQ_END: push_byte(CH_QUOTE, 1'b1);
			REQ_DATA: begin
				case (b)
					CH_QUOTE, CH_BSLASH: short_code = b;
					CH_BS:  short_code = CH_B;
					CH_FF:  short_code = CH_F;
					CH_LF:  short_code = CH_N;
					CH_CR:  short_code = CH_R;
					CH_TAB: short_code = CH_T;
					default: is_short = 1'b0;
				endcase
				if (is_short) begin
					push_byte(CH_BSLASH, 1'b0);
					push_byte(short_code, 1'b1);
				end else if (b < CTRL_LIMIT) begin
					// \u00XX with lowercase hex
					push_byte(CH_BSLASH, 1'b0);
					push_byte(CH_U, 1'b0);
					push_byte(CH_ZERO, 1'b0);
					push_byte(CH_ZERO, 1'b0);
					push_byte(hex_digits[b[7:4]], 1'b0);
					push_byte(hex_digits[b[3:0]], 1'b1);
				end else begin
					push_byte(b, 1'b1);
				end
			end
			default: ; // unused code: no output
		endcase
	endfunction

	// Compare output transactions, then queue predictions for the input side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escaped_q.delete();
			mismatches = 0;
			checked = 0;
			error_count <= 0;
			bytes_pending <= 0;
			bytes_checked <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (escaped_q.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("[%0t] unexpected output: byte %h last %b",
							$realtime, out_byte, last_of_run);
				end else begin
					want = escaped_q.pop_front();
					checked++;
					if (want.char_val !== out_byte || want.last !== last_of_run) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display("[%0t] mismatch: expected byte %h last %b, got byte %h last %b",
								$realtime, want.char_val, want.last, out_byte, last_of_run);
					end
				end
			end
			if (in_valid && in_ready)
				expand_item(req_t'(req_type), data_byte);
			error_count <= mismatches;
			bytes_pending <= escaped_q.size();
			bytes_checked <= checked;
		end
	end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the JSON string escaper testbench: clock, reset, framed string stimulus,
// output stalls and verdict. Depends on jse_pkg, json_string_escaper and json_escape_checker.
module testbench;
	import jse_pkg::*;

	localparam int HALF_PERIOD  = 6;
	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_ITEMS = 100;
	localparam int HOLD_AFTER   = 40;
	localparam int HOLD_CYCLES  = 100;
	localparam int DRAIN_CYCLES = 8;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] req_type;
	logic [7:0] data_byte;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic       last_of_run;

	int error_count;
	int bytes_pending;
	int bytes_checked;
	int items_sent;
	int burst_left;
	int idle_cycles;
	bit holding_off;
	bit hold_done;

	json_string_escaper DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.data_byte  (data_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.last_of_run(last_of_run)
	);

	json_escape_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.last_of_run  (last_of_run),
		.error_count  (error_count),
		.bytes_pending(bytes_pending),
		.bytes_checked(bytes_checked)
	);

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	// Offer one transaction, with a random gap at the start of each burst
	task automatic send_item(input req_t kind, input logic [7:0] b);
		int gap;
		if (burst_left == 0 && !holding_off) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 10);
		end
		if (burst_left > 0)
			burst_left--;
		in_valid <= 1'b1;
		req_type <= kind;
		data_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	// Random string byte, weighted toward escapes and control codes
	function automatic logic [7:0] pick_byte();
		logic [7:0] r;
		case ($urandom_range(0, 9))
			0, 1: begin
				case ($urandom_range(0, 6))
					0: r = CH_QUOTE;
					1: r = CH_BSLASH;
					2: r = CH_BS;
					3: r = CH_FF;
					4: r = CH_LF;
					5: r = CH_CR;
					default: r = CH_TAB;
				endcase
			end
			2, 3: r = 8'($urandom_range(0, 31));
			4, 5, 6: r = 8'($urandom_range(32, 126));
			7: r = 8'($urandom_range(128, 255));
			default: r = 8'($urandom_range(0, 255));
		endcase
		return r;
	endfunction

	// Output stalls: segments of a random pattern, plus one long hold-off
	initial begin
		int mode;
		int span;
		int period;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(10, 50);
			period = $urandom_range(2, 4);
			for (int k = 0; k < span; k++) begin
				if (!hold_done && items_sent >= HOLD_AFTER) begin
					holding_off = 1'b1;
					out_ready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
					holding_off = 1'b0;
					hold_done = 1'b1;
				end
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ((k % period) == 0);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// Watchdog: no transaction on either channel for too long
	initial begin
		idle_cycles = 0;
		wait (arst_n === 1'b1);
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("No transaction for %0d cycles, %0d bytes still expected",
			IDLE_LIMIT, bytes_pending);
		$display("Verification failed");
		$finish;
	end

	// Stimulus and verdict
	initial begin
		int noise;
		int len;
		int data_items;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_DATA;
		data_byte = 8'h00;
		items_sent = 0;
		burst_left = 0;
		data_items = 0;
		holding_off = 1'b0;
		hold_done = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: framing, every escape class, field extremes, ignored codes
		send_item(REQ_START, 8'hAA);
		send_item(REQ_DATA, 8'h00);
		send_item(REQ_DATA, 8'h1F);
		send_item(REQ_DATA, 8'h1A);
		send_item(REQ_DATA, CH_QUOTE);
		send_item(REQ_DATA, CH_BSLASH);
		send_item(REQ_DATA, CH_BS);
		send_item(REQ_DATA, CH_FF);
		send_item(REQ_DATA, CH_LF);
		send_item(REQ_DATA, CH_CR);
		send_item(REQ_DATA, CH_TAB);
		send_item(REQ_DATA, 8'h0B);
		send_item(REQ_DATA, 8'h20);
		send_item(REQ_DATA, 8'h7F);
		send_item(REQ_DATA, 8'h80);
		send_item(REQ_DATA, 8'hFF);
		send_item(REQ_DATA, 8'h41);
		send_item(REQ_END, 8'h55);
		send_item(REQ_NONE, 8'hFF);
		send_item(REQ_NONE, 8'h00);
		send_item(REQ_END, 8'h00);
		send_item(REQ_START, 8'hFF);

		// Random: mostly framed strings, some stray codes and unterminated strings
		while (data_items < RANDOM_ITEMS) begin
			noise = $urandom_range(0, 9);
			if (noise == 0) begin
				send_item(REQ_NONE, 8'($urandom_range(0, 255)));
			end else if (noise == 1) begin
				send_item(REQ_END, 8'($urandom_range(0, 255)));
				data_items++;
			end else begin
				send_item(REQ_START, 8'($urandom_range(0, 255)));
				data_items++;
				len = $urandom_range(0, 8);
				repeat (len) begin
					send_item(REQ_DATA, pick_byte());
					data_items++;
				end
				if ($urandom_range(0, 7) != 0) begin
					send_item(REQ_END, 8'($urandom_range(0, 255)));
					data_items++;
				end
			end
		end
		in_valid <= 1'b0;

		// Drain everything still expected, then a few more cycles
		@(posedge clk);
		while (bytes_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d input transactions (%0d framed in the random part), checked %0d bytes",
			items_sent, data_items, bytes_checked);
		$display("Output hold-off of %0d cycles %s", HOLD_CYCLES,
			hold_done ? "exercised" : "not reached");
		if (error_count == 0 && bytes_pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches, %0d bytes never arrived", error_count, bytes_pending);
			$display("Verification failed");
		end
		$finish;
	end

endmodule
